### design/focuser_command_protocol_top_assert.svh
// Assertion macros for the focuser command protocol block.
`ifndef FOCUSER_COMMAND_PROTOCOL_TOP_ASSERT_SVH
`define FOCUSER_COMMAND_PROTOCOL_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define FCP_ASSERT(lbl, clk_i, rst_n_i, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) prop) \
	else $error("fcp assertion failed");
// Check a property on every clock edge, reset included.
`define FCP_ASSERT_ALWAYS(lbl, clk_i, prop) \
	lbl: assert property (@(posedge clk_i) prop) else $error("fcp assertion failed");
`else
`define FCP_ASSERT(lbl, clk_i, rst_n_i, prop)
`define FCP_ASSERT_ALWAYS(lbl, clk_i, prop)
`endif
`endif

### design/fcp_pkg.sv
// Types, constants and helper functions of the focuser command protocol block.
package fcp_pkg;
	localparam int unsigned LINE_CHARS_DEF = 7;
	localparam int unsigned HOME_TARGET_DEF = 8000;
	localparam int unsigned VAL_W = 20;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	localparam logic [15:0] KEY_GP = 16'h4750;
	localparam logic [15:0] KEY_GN = 16'h474E;
	localparam logic [15:0] KEY_GC = 16'h4743;
	localparam logic [15:0] KEY_ZX = 16'h5A58;
	localparam logic [15:0] KEY_GH = 16'h4748;
	localparam logic [15:0] KEY_GI = 16'h4749;
	localparam logic [15:0] KEY_GD = 16'h4744;
	localparam logic [15:0] KEY_GV = 16'h4756;
	localparam logic [15:0] KEY_GT = 16'h4754;
	localparam logic [15:0] KEY_SC = 16'h5343;
	localparam logic [15:0] KEY_YX = 16'h5958;
	localparam logic [15:0] KEY_SF = 16'h5346;
	localparam logic [15:0] KEY_SH = 16'h5348;
	localparam logic [15:0] KEY_FQ = 16'h4651;
	localparam logic [15:0] KEY_FG = 16'h4647;
	localparam logic [15:0] KEY_FI = 16'h4649;
	localparam logic [15:0] KEY_FO = 16'h464F;
	localparam logic [15:0] KEY_SD = 16'h5344;
	localparam logic [15:0] KEY_SP = 16'h5350;
	localparam logic [15:0] KEY_RS = 16'h5253;
	localparam logic [15:0] KEY_SN = 16'h534E;
	localparam logic [15:0] KEY_PH = 16'h5048;

	localparam logic [VAL_W-1:0] FW_VERSION = 20'h00010;
	localparam logic [VAL_W-1:0] TEMP_STUB = 20'd20;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_STEP = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_TICK, ST_TICK_DEC, ST_PARSE, ST_EXEC,
		ST_TGT_DN, ST_TGT_UP, ST_HEX, ST_ECHO
	} state_t;

	typedef enum logic {ALU_ADD, ALU_SUB} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [VAL_W-1:0] a;
		logic [VAL_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [VAL_W-1:0] y;
		logic             borrow;
	} alu_rsp_t;

	typedef struct packed {
		logic       valid;
		logic       kind;
		logic [7:0] ch;
		logic       up;
		logic [2:0] spd;
		logic       last;
	} beat_t;

	// Hex digit value of a character: {valid, nibble}.
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
		return r;
	endfunction

	function automatic logic [7:0] upper(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		return (d < 4'd10) ? 8'h30 + {4'd0, d} : 8'h37 + {4'd0, d};
	endfunction

	// Digits to print: significant nibbles, at least min_d.
	function automatic logic [2:0] hex_digits(input logic [VAL_W-1:0] v,
			input logic [2:0] min_d);
		logic [2:0] n;
		n = 3'd1;
		if (v[19:16] != 4'd0) n = 3'd5;
		else if (v[15:12] != 4'd0) n = 3'd4;
		else if (v[11:8] != 4'd0) n = 3'd3;
		else if (v[7:4] != 4'd0) n = 3'd2;
		return (n < min_d) ? min_d : n;
	endfunction
endpackage

### design/fcp_alu.sv
// Shared 20-bit add/subtract unit with borrow out.
module fcp_alu (
	input  fcp_pkg::alu_req_t req,
	output fcp_pkg::alu_rsp_t rsp
);
	import fcp_pkg::*;

	logic [VAL_W:0] sum;

	// Add or subtract, keep the borrow of a subtraction
	always_comb begin
		unique case (req.op)
			ALU_ADD: sum = {1'b0, req.a} + {1'b0, req.b};
			ALU_SUB: sum = {1'b0, req.a} - {1'b0, req.b};
			default: sum = '0;
		endcase
		rsp.y = sum[VAL_W-1:0];
		rsp.borrow = (req.op == ALU_SUB) ? sum[VAL_W] : 1'b0;
	end
endmodule

### design/focuser_command_protocol_top.sv
// Top level of the focuser command protocol block: sequencer, state and output beat.
//
// A serial byte is taken while the sequencer is idle. A '#' that closes a
// frame of two or more characters then runs a sequence: the parse state
// reads the value digits, the decode state acts on the command, then any reply
// characters (up to six) are sent or the target states work out a new target.
// A motor tick steps the position and then counts down the steps left, or
// ends without either when motion is stopped or finished.
// The 20-bit add/subtract unit is shared by the target compare, the position
// step and the step count, and the sequencer handles one item at a time;
// in_stall is high while it works, which takes in waiting on out_stall before a beat is loaded.
module focuser_command_protocol_top #(
	parameter int unsigned LINE_CHARS = fcp_pkg::LINE_CHARS_DEF,
	parameter int unsigned HOME_TARGET = fcp_pkg::HOME_TARGET_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       cmd,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       kind,
	output logic [7:0] reply_char,
	output logic       step_up,
	output logic [2:0] step_speed,
	output logic       last
);
	import fcp_pkg::*;

	localparam int unsigned IDX_W = $clog2(LINE_CHARS);
	localparam int unsigned LEN_W = $clog2(LINE_CHARS + 1);

	state_t state_q, state_d;
	logic [7:0] buf_q [LINE_CHARS];
	logic [LEN_W-1:0] len_q, idx_q;
	logic [VAL_W-1:0] last_value_q, position_q, target_q, steps_q, acc_q, rv_q;
	logic moving_up_q, running_q, half_step_q, echo_q;
	logic [2:0] speed_q, dig_q;
	logic [15:0] coeff_q, max_steps_q;
	logic out_valid_q;
	beat_t out_q, beat;
	alu_req_t alu_req;
	alu_rsp_t alu_rsp;
	logic out_free, accept;
	logic [4:0] hv;
	logic [15:0] key;
	logic [7:0] cur_ch;

	fcp_alu u_alu (.req(alu_req), .rsp(alu_rsp));

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign cur_ch = buf_q[idx_q[IDX_W-1:0]];
	assign hv = hex_val(cur_ch);
	assign key = {upper(buf_q[0]), upper(buf_q[1])};

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd) state_d = ST_TICK;
					else if (rx_byte == CH_HASH && len_q >= LEN_W'(2)) state_d = ST_PARSE;
				end
			end
			ST_TICK: begin
				if (!running_q || steps_q == '0) state_d = ST_IDLE;
				else if (out_free) state_d = ST_TICK_DEC;
			end
			ST_TICK_DEC: state_d = ST_IDLE;
			ST_PARSE: begin
				if (!(idx_q < len_q && hv[4])) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				priority case (key)
					KEY_GP, KEY_GN, KEY_GC, KEY_ZX, KEY_GH, KEY_GI, KEY_GD, KEY_GV,
					KEY_GT: state_d = ST_HEX;
					KEY_FI, KEY_FO: state_d = ST_ECHO;
					KEY_SN, KEY_PH: state_d = ST_TGT_DN;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_TGT_DN: state_d = alu_rsp.borrow ? ST_TGT_UP : ST_IDLE;
			ST_TGT_UP: state_d = ST_IDLE;
			ST_HEX: begin
				if (out_free && dig_q == 3'd0) state_d = ST_IDLE;
			end
			ST_ECHO: begin
				if (out_free && echo_q) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Shared unit operands and the beat to send
	always_comb begin
		alu_req = '{op: ALU_SUB, a: steps_q, b: VAL_W'(1)};
		beat = '0;
		unique case (state_q)
			ST_TICK: begin
				alu_req = '{op: moving_up_q ? ALU_ADD : ALU_SUB, a: position_q, b: VAL_W'(1)};
				beat = '{valid: running_q && steps_q != '0 && out_free, kind: KIND_STEP,
					ch: 8'd0, up: moving_up_q, spd: speed_q, last: 1'b1};
			end
			ST_TGT_DN: alu_req = '{op: ALU_SUB, a: position_q, b: target_q};
			ST_TGT_UP: alu_req = '{op: ALU_SUB, a: target_q, b: position_q};
			ST_HEX: begin
				beat.valid = out_free;
				beat.kind = KIND_CHAR;
				beat.last = (dig_q == 3'd0);
				unique case (dig_q)
					3'd1: beat.ch = hex_char(rv_q[3:0]);
					3'd2: beat.ch = hex_char(rv_q[7:4]);
					3'd3: beat.ch = hex_char(rv_q[11:8]);
					3'd4: beat.ch = hex_char(rv_q[15:12]);
					3'd5: beat.ch = hex_char(rv_q[19:16]);
					default: beat.ch = CH_HASH;
				endcase
			end
			ST_ECHO: begin
				beat.valid = out_free;
				beat.kind = KIND_CHAR;
				beat.ch = echo_q ? buf_q[1] : buf_q[0];
				beat.last = echo_q;
			end
			default: ;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q <= '0;
			last_value_q <= '0;
			position_q <= '0;
			target_q <= '0;
			steps_q <= '0;
			moving_up_q <= 1'b1;
			running_q <= 1'b0;
			half_step_q <= 1'b0;
			speed_q <= 3'd1;
			coeff_q <= 16'd1;
			max_steps_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// hold the beat while stalled, load a new one when sent
			if (beat.valid) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					// clear on ':' or a short frame's '#'; a long frame keeps its length
					if (accept && !cmd) begin
						if (rx_byte == CH_COLON || (rx_byte == CH_HASH && len_q < LEN_W'(2)))
							len_q <= '0;
						else if (rx_byte != CH_HASH && rx_byte != CH_CR && rx_byte != CH_LF &&
								len_q < LEN_W'(LINE_CHARS))
							len_q <= len_q + LEN_W'(1);
					end
				end
				ST_TICK: begin
					if (running_q && steps_q == '0) running_q <= 1'b0;
					else if (running_q && out_free) position_q <= alu_rsp.y;
				end
				ST_TICK_DEC: steps_q <= alu_rsp.y;
				ST_PARSE: begin
					if (!(idx_q < len_q && hv[4]) && len_q > LEN_W'(2))
						last_value_q <= acc_q;
				end
				ST_EXEC: begin
					len_q <= '0;
					priority case (key)
						KEY_SC: coeff_q <= last_value_q[15:0];
						KEY_YX: max_steps_q <= last_value_q[15:0];
						KEY_SF: half_step_q <= 1'b0;
						KEY_SH: half_step_q <= 1'b1;
						KEY_FQ: running_q <= 1'b0;
						KEY_FG: running_q <= 1'b1;
						KEY_SD: begin
							if (last_value_q >= VAL_W'(2) && last_value_q <= VAL_W'(32)) begin
								priority if (last_value_q[5]) speed_q <= 3'd5;
								else if (last_value_q[4]) speed_q <= 3'd4;
								else if (last_value_q[3]) speed_q <= 3'd3;
								else if (last_value_q[2]) speed_q <= 3'd2;
								else speed_q <= 3'd1;
							end
						end
						KEY_SP: position_q <= last_value_q;
						KEY_RS: position_q <= '0;
						KEY_SN: target_q <= last_value_q;
						KEY_PH: begin
							target_q <= VAL_W'(HOME_TARGET);
							running_q <= 1'b1;
						end
						default: ;
					endcase
				end
				ST_TGT_DN: begin
					if (!alu_rsp.borrow) begin
						moving_up_q <= 1'b0;
						steps_q <= alu_rsp.y;
					end
				end
				ST_TGT_UP: begin
					moving_up_q <= 1'b1;
					steps_q <= alu_rsp.y;
				end
				default: ;
			endcase
		end
	end

	// Payload: line buffer, parse and reply registers, output beat
	always_ff @(posedge clk) begin
		if (beat.valid) out_q <= beat;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !cmd && rx_byte != CH_COLON && rx_byte != CH_HASH &&
						rx_byte != CH_CR && rx_byte != CH_LF && len_q < LEN_W'(LINE_CHARS))
					buf_q[len_q[IDX_W-1:0]] <= rx_byte;
				idx_q <= LEN_W'(2);
				acc_q <= '0;
			end
			ST_PARSE: begin
				if (idx_q < len_q && hv[4]) begin
					acc_q <= {acc_q[VAL_W-5:0], hv[3:0]};
					idx_q <= idx_q + LEN_W'(1);
				end
			end
			ST_EXEC: begin
				echo_q <= 1'b0;
				priority case (key)
					KEY_GP: begin rv_q <= position_q; dig_q <= hex_digits(position_q, 3'd1); end
					KEY_GN: begin rv_q <= target_q; dig_q <= hex_digits(target_q, 3'd1); end
					KEY_GC: begin
						rv_q <= VAL_W'(coeff_q);
						dig_q <= hex_digits(VAL_W'(coeff_q), 3'd2);
					end
					KEY_ZX: begin
						rv_q <= VAL_W'(max_steps_q);
						dig_q <= hex_digits(VAL_W'(max_steps_q), 3'd4);
					end
					KEY_GH: begin rv_q <= VAL_W'(half_step_q); dig_q <= 3'd2; end
					KEY_GI: begin rv_q <= VAL_W'(running_q); dig_q <= 3'd2; end
					KEY_GD: begin
						rv_q <= VAL_W'(9'd2 << (speed_q - 3'd1));
						dig_q <= hex_digits(VAL_W'(9'd2 << (speed_q - 3'd1)), 3'd2);
					end
					KEY_GV: begin rv_q <= FW_VERSION; dig_q <= 3'd2; end
					KEY_GT: begin rv_q <= TEMP_STUB; dig_q <= 3'd2; end
					default: ;
				endcase
			end
			ST_HEX: begin
				if (out_free && dig_q != 3'd0) dig_q <= dig_q - 3'd1;
			end
			ST_ECHO: begin
				if (out_free) echo_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign kind = out_q.kind;
	assign reply_char = out_q.ch;
	assign step_up = out_q.up;
	assign step_speed = out_q.spd;
	assign last = out_q.last;

`include "focuser_command_protocol_top_assert.svh"
	`FCP_ASSERT(a_len_bound, clk, arst_n, len_q <= LEN_W'(LINE_CHARS))
	`FCP_ASSERT(a_speed_range, clk, arst_n, speed_q >= 3'd1 && speed_q <= 3'd5)
	`FCP_ASSERT(a_step_when_running, clk, arst_n, beat.valid && beat.kind == KIND_STEP |-> running_q && steps_q != '0)
	`FCP_ASSERT(a_tick_counts_down, clk, arst_n, state_q == ST_TICK_DEC |=> steps_q == $past(steps_q) - VAL_W'(1))
	`FCP_ASSERT_ALWAYS(a_idle_in_reset, clk, !arst_n |-> state_q == ST_IDLE && !out_valid_q)
endmodule
